// ----- hw/rtl/cpba_pkg.sv -----
package cpba_pkg;

  localparam int unsigned CardCount  = 4;
  localparam int unsigned CardBytes  = 32768;
  localparam int unsigned BlockBytes = 32;

  localparam logic [7:0]  CrcPoly    = 8'h85;
  localparam logic [15:0] BlockMask  = 16'hffe0;
  localparam logic [15:0] TopBlock   = 16'h7fe0;
  localparam logic [4:0]  LastBeat   = 5'd31;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } cpba_action_e;

  typedef struct packed {
    cpba_action_e action;
    logic [1:0]   channel;
    logic [15:0]  block_address;
    logic [4:0]   beat_index;
    logic [7:0]   write_data;
  } cpba_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] block_crc;
    logic       last_beat;
    logic       in_range;
  } cpba_out_t;

  typedef struct packed {
    logic load;
    logic first;
    logic fold;
    logic clear;
  } cpba_crc_cmd_t;

  function automatic logic [7:0] crc_bit_step(logic [7:0] crc, logic din);
    logic [7:0] tap;
    tap = crc[7] ? CrcPoly : 8'h00;
    return {crc[6:0], din} ^ tap;
  endfunction

endpackage

// ----- hw/rtl/controller_pak_block_access_core.sv -----
// Memory card block access. Each accepted item is one byte beat of a 32-byte
// block transfer; each gives one result item. A beat passes through the card
// memory access, the registered read, then the shift state in which the CRC-8
// unit folds the data byte in one bit per cycle; on beat 31 the CRC unit then
// shifts eight zero bits through in the flush state. The done state hands the
// result to the output register once that register is free; it holds the
// result until taken while the next item is accepted. Card contents are
// undefined until written.
module controller_pak_block_access_core #(
  parameter int unsigned CARD_COUNT = cpba_pkg::CardCount,
  parameter int unsigned CARD_BYTES = cpba_pkg::CardBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpba_pkg::cpba_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpba_pkg::cpba_out_t out_item_o
);

  import cpba_pkg::*;

  localparam int unsigned Depth = CARD_COUNT * CARD_BYTES;
  localparam int unsigned MemAw = $clog2(Depth);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MEM   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_DONE  = 6'b100000
  } cpba_state_e;

  cpba_state_e   state_q, state_d;
  logic [2:0]    cnt_q, cnt_d;
  cpba_in_t      item_q;
  logic [7:0]    byte_q;
  cpba_out_t     out_q;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic          out_free;
  logic          last;
  logic          ok;
  logic [15:0]   base;
  logic [16:0]   base_end;
  logic [MemAw-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_rdata;
  logic [7:0]    load_byte;
  logic [7:0]    crc;
  cpba_crc_cmd_t crc_cmd;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (item_q.beat_index == LastBeat);

  assign base     = item_q.block_address & BlockMask;
  assign base_end = {1'b0, base} + 17'(BlockBytes);
  assign ok       = (base <= TopBlock) && (base_end <= 17'(CARD_BYTES))
                    && ({30'd0, item_q.channel} < CARD_COUNT);
  assign mem_addr = MemAw'(item_q.channel * CARD_BYTES) + MemAw'(base)
                    + MemAw'(item_q.beat_index);
  assign mem_we   = (state_q == ST_MEM) && (item_q.action == ACT_WRITE) && ok;

  assign load_byte = (item_q.action == ACT_WRITE) ? item_q.write_data
                   : (ok ? mem_rdata : 8'h00);

  cpba_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(item_q.write_data),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    crc_cmd       = '0;
    crc_cmd.load  = (state_q == ST_LOAD);
    crc_cmd.first = (item_q.beat_index == '0);
    crc_cmd.fold  = (state_q == ST_SHIFT) || (state_q == ST_FLUSH);
    crc_cmd.clear = (state_q == ST_DONE) && out_free && last;
  end

  cpba_crc u_crc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (crc_cmd),
    .byte_i(load_byte),
    .crc_o (crc)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = last ? ST_FLUSH : ST_DONE;
        end
      end
      ST_FLUSH: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_LOAD) begin
      byte_q <= load_byte;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.read_data <= byte_q;
      out_q.block_crc <= last ? crc : 8'h00;
      out_q.last_beat <= last;
      out_q.in_range  <= ok;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/cpba_store.sv -----
module cpba_store #(
  parameter int unsigned Depth = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cpba_crc.sv -----
module cpba_crc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cpba_pkg::cpba_crc_cmd_t cmd_i,
  input  logic [7:0]             byte_i,
  output logic [7:0]             crc_o
);

  import cpba_pkg::*;

  logic [7:0] sr_q, sr_d;
  logic [7:0] crc_q, crc_d;

  always_comb begin
    sr_d  = sr_q;
    crc_d = crc_q;
    if (cmd_i.load) begin
      sr_d = byte_i;
      if (cmd_i.first) begin
        crc_d = 8'h00;
      end
    end else if (cmd_i.fold) begin
      sr_d  = {sr_q[6:0], 1'b0};
      crc_d = crc_bit_step(crc_q, sr_q[7]);
    end else if (cmd_i.clear) begin
      crc_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 8'h00;
    end else begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign crc_o = crc_q;

endmodule

// ----- hw/rtl/cpba_checker.sv -----
module cpba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input cpba_pkg::cpba_in_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cpba_pkg::cpba_out_t out_item_o
);

  import cpba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  a_crc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_beat |-> out_item_o.block_crc == 8'h00)
    else $error("crc shown on a beat other than the last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new item taken while one is in work");

endmodule

bind controller_pak_block_access_core cpba_checker u_cpba_checker (.*);

// ----- bench/card_beat_checker.sv -----
`timescale 1ns / 1ps

module card_beat_checker
  import cpba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  cpba_in_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  cpba_out_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [7:0] card_image [int];
  logic [7:0] crc_acc_q = 8'h00;
  cpba_out_t  expected_beats_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [7:0] crc8_shift_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] acc;
    acc = crc;
    for (int b = 7; b >= 0; b--) begin
      acc = {acc[6:0], data[b]} ^ (acc[7] ? CrcPoly : 8'h00);
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at %0t: %s got %02h want %02h", $realtime, field, got, want);
    fail_count_o++;
  endtask

  task automatic predict_beat(input cpba_in_t item);
    logic [15:0] base;
    logic        ok;
    logic [7:0]  data_byte;
    logic [7:0]  crc;
    int          key;
    cpba_out_t   want;
    base = item.block_address & BlockMask;
    ok   = (base <= TopBlock) && (int'(base) + BlockBytes <= CardBytes)
           && (int'(item.channel) < CardCount);
    key  = int'(item.channel) * CardBytes + int'(base) + int'(item.beat_index);
    if (item.action == ACT_WRITE) begin
      data_byte = item.write_data;
      if (ok) begin
        card_image[key] = item.write_data;
      end
    end else begin
      data_byte = (ok && card_image.exists(key)) ? card_image[key] : 8'h00;
    end
    crc = (item.beat_index == 5'd0) ? 8'h00 : crc_acc_q;
    crc = crc8_shift_byte(crc, data_byte);
    want.read_data = data_byte;
    want.last_beat = (item.beat_index == LastBeat);
    want.in_range  = ok;
    if (want.last_beat) begin
      want.block_crc = crc8_shift_byte(crc, 8'h00);
      crc_acc_q      = 8'h00;
    end else begin
      want.block_crc = 8'h00;
      crc_acc_q      = crc;
    end
    expected_beats_q.push_back(want);
  endtask

  task automatic check_beat(input cpba_out_t got);
    cpba_out_t want;
    if (expected_beats_q.size() == 0) begin
      report_mismatch("unexpected item, read_data", got.read_data, 8'h00);
      return;
    end
    want = expected_beats_q.pop_front();
    if (got.read_data !== want.read_data) begin
      report_mismatch("read_data", got.read_data, want.read_data);
    end
    if (got.block_crc !== want.block_crc) begin
      report_mismatch("block_crc", got.block_crc, want.block_crc);
    end
    if (got.last_beat !== want.last_beat) begin
      report_mismatch("last_beat", {7'd0, got.last_beat}, {7'd0, want.last_beat});
    end
    if (got.in_range !== want.in_range) begin
      report_mismatch("in_range", {7'd0, got.in_range}, {7'd0, want.in_range});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc_q = 8'h00;
      expected_beats_q.delete();
      card_image.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_beat(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_beat(out_item_i);
      end
    end
    pending_o = expected_beats_q.size();
  end

endmodule

// ----- bench/controller_pak_block_access_core_tb.sv -----
`timescale 1ns / 1ps

module controller_pak_block_access_core_tb;
  import cpba_pkg::*;

  localparam int RandomBeats = 1250;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  cpba_in_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  cpba_out_t out_item_o;

  int fail_count;
  int pending;
  int beats_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;

  bit byte_written [0:CardCount*CardBytes-1];
  int written_blocks_q [$];

  controller_pak_block_access_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  card_beat_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic bit block_in_range(logic [15:0] addr);
    return (addr & BlockMask) <= TopBlock;
  endfunction

  function automatic int card_key(logic [1:0] ch, logic [15:0] addr, logic [4:0] beat);
    return int'(ch) * CardBytes + int'(addr & BlockMask) + int'(beat);
  endfunction

  task automatic send_beat(input cpba_action_e act, input logic [1:0] ch,
                           input logic [15:0] addr, input logic [4:0] beat,
                           input logic [7:0] data);
    cpba_in_t item;
    item.action        = act;
    item.channel       = ch;
    item.block_address = addr;
    item.beat_index    = beat;
    item.write_data    = data;
    if (act == ACT_WRITE && block_in_range(addr)) begin
      byte_written[card_key(ch, addr, beat)] = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_block(input cpba_action_e act, input logic [1:0] ch,
                            input logic [15:0] addr, input int count, input bit scramble);
    logic [4:0] beat;
    logic [7:0] data;
    for (int i = 0; i < count; i++) begin
      beat = scramble ? 5'($urandom_range(31)) : i[4:0];
      data = 8'($urandom_range(255));
      send_beat(act, ch, addr, beat, data);
    end
    if (act == ACT_WRITE && !scramble && count == BlockBytes && block_in_range(addr)) begin
      written_blocks_q.push_back(card_key(ch, addr, 5'd0));
    end
  endtask

  task automatic pick_written_block(output logic [1:0] ch, output logic [15:0] addr);
    int key;
    key  = written_blocks_q[$urandom_range(written_blocks_q.size() - 1)];
    ch   = 2'(key / CardBytes);
    addr = 16'((key % CardBytes) | $urandom_range(31));
  endtask

  initial begin
    int           random_start;
    int           phase;
    int           sel;
    int           count;
    logic [1:0]   ch;
    logic [15:0]  addr;
    logic [4:0]   beat;
    cpba_action_e act;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ACT_WRITE, 2'd3, 16'h7fff, 5'd0, 8'hff);
    send_beat(ACT_WRITE, 2'd3, 16'h7fff, 5'd1, 8'h00);
    send_beat(ACT_WRITE, 2'd3, 16'h7fff, 5'd2, 8'ha5);
    send_beat(ACT_READ,  2'd3, 16'h7fe0, 5'd0, 8'h3c);
    send_beat(ACT_READ,  2'd3, 16'h7fe1, 5'd1, 8'h00);
    send_beat(ACT_READ,  2'd3, 16'h7fe0, 5'd2, 8'hff);
    send_beat(ACT_WRITE, 2'd0, 16'h0000, 5'd0, 8'h00);
    send_beat(ACT_WRITE, 2'd0, 16'h0000, 5'd31, 8'hff);
    send_beat(ACT_READ,  2'd0, 16'h001f, 5'd0, 8'h00);
    send_beat(ACT_READ,  2'd0, 16'h001f, 5'd31, 8'h00);
    send_beat(ACT_WRITE, 2'd1, 16'h8001, 5'd0, 8'h5a);
    send_beat(ACT_WRITE, 2'd1, 16'h8001, 5'd31, 8'hc3);
    send_beat(ACT_READ,  2'd2, 16'h8000, 5'd0, 8'h00);
    send_beat(ACT_READ,  2'd2, 16'hffff, 5'd31, 8'hff);
    send_beat(ACT_WRITE, 2'd2, 16'hffe0, 5'd17, 8'h81);
    send_beat(ACT_WRITE, 2'd3, 16'h7fe0, 5'd31, 8'h01);
    send_beat(ACT_READ,  2'd3, 16'h7ffe, 5'd31, 8'h00);
    send_beat(ACT_READ,  2'd0, 16'h0000, 5'd0, 8'h00);
    send_beat(ACT_READ,  2'd0, 16'h0000, 5'd31, 8'h00);

    random_start = beats_sent;
    hold_req <= 1'b1;
    while (beats_sent < random_start + RandomBeats) begin
      phase = (beats_sent - random_start) * 4 / RandomBeats;
      case (phase)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct <= 81;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct     <= 81;
        end
        default: begin
          send_idle_pct <= 7;
          stall_pct     <= 7;
        end
      endcase
      sel  = $urandom_range(99);
      ch   = 2'($urandom_range(3));
      addr = 16'($urandom_range(16'h7fff));
      if (sel < 40 || (written_blocks_q.size() == 0 && sel < 83)) begin
        send_block(ACT_WRITE, ch, addr, BlockBytes, 1'b0);
      end else if (sel < 62) begin
        pick_written_block(ch, addr);
        send_block(ACT_READ, ch, addr, BlockBytes, 1'b0);
      end else if (sel < 75) begin
        count = $urandom_range(1, 31);
        if ($urandom_range(1)) begin
          send_block(ACT_WRITE, ch, addr, count, 1'b0);
        end else begin
          pick_written_block(ch, addr);
          send_block(ACT_READ, ch, addr, count, 1'b0);
        end
      end else if (sel < 83) begin
        count = $urandom_range(1, 40);
        if ($urandom_range(1)) begin
          addr = 16'($urandom_range(16'hffff));
          send_block(ACT_WRITE, ch, addr, count, 1'b1);
        end else begin
          pick_written_block(ch, addr);
          send_block(ACT_READ, ch, addr, count, 1'b1);
        end
      end else if (sel < 92) begin
        act  = cpba_action_e'($urandom_range(1));
        addr = 16'h8000 | 16'($urandom_range(16'h7fff));
        send_block(act, ch, addr, BlockBytes, 1'b0);
      end else begin
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++) begin
          act  = cpba_action_e'($urandom_range(1));
          ch   = 2'($urandom_range(3));
          addr = 16'($urandom_range(16'hffff));
          beat = 5'($urandom_range(31));
          if (act == ACT_READ && block_in_range(addr)
              && !byte_written[card_key(ch, addr, beat)]) begin
            act = ACT_WRITE;
          end
          send_beat(act, ch, addr, beat, 8'($urandom_range(255)));
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
